// ===== sv/bca_pkg.sv =====
// Shared constants and helpers for the bitmap cell allocator.
// Field widths, action and status codes, and the lowest-free-bit search.
// No dependencies.
package bca_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int CELL_IDX_W = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int BUS_W      = 16;

    // Bitmap word geometry: eight cells per stored word
    localparam int WORD_W     = 8;
    localparam int BIT_W      = 3;

    // Defaults
    localparam int                 CELLS_DEFAULT = 256;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 9'd256;

    // Action codes (any other code behaves as a query)
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_WAS_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd3;

    // Lowest clear bit of a word: {found, position}
    function automatic logic [BIT_W:0] low_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/bca_map.sv =====
// Busy bitmap storage: word memory with registered read,
// per-word valid bits (unwritten words read as free) and a full-word summary.
// Depends on bca_pkg.
module bca_map
    import bca_pkg::*;
#(
    parameter int WORDS = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    output logic              free_found,
    output logic [AW-1:0]     free_word
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]  valid_reg;
    logic [WORDS-1:0]  full_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_in_range;

    assign rd_in_range = (rd_addr <= AW'(WORDS - 1));

    // Memory array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en && rd_in_range)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits and full summary, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            full_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                full_reg[wr_addr]  <= &wr_data;
            end
            if (rd_en)
            begin
                rd_valid_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    // Lowest word with at least one free cell
    always_comb
    begin
        free_found = 1'b0;
        free_word  = '0;
        for (int w = WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                free_found = 1'b1;
                free_word  = AW'(w);
            end
        end
    end

endmodule

// ===== sv/bitmap_cell_allocator_unit.sv =====
// Top level of the bitmap cell allocator: stream ports, request sequencer.
// Depends on bca_pkg and bca_map.
//
// First-fit cell allocator over a busy bitmap held eight cells to a memory word.
// Each request word passes through ST_IDLE, which locates and reads the bitmap word
// (the word named by the cell index, or for allocate the lowest word that the
// full-word summary shows as not full), then ST_RMW, which modifies it, writes it
// back and loads the result register. The single read-modify-write on the bitmap
// memory sets the rate: one request at a time, and ST_RMW waits while the result stalls.
// The bitmap reads as all free straight after reset; no clearing pass is needed.
// The cell count register may only be written while no request is in flight.
module bitmap_cell_allocator_unit
    import bca_pkg::*;
#(
    parameter int CELLS = CELLS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration: cell count
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    // Requests
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BUS_W-1:0]   s_axis_tdata,  // [1:0] action, [9:2] cell_index
    // Results
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BUS_W-1:0]   m_axis_tdata   // [7:0] result_index, [9:8] status,
                                              // [10] cell_busy
);

    // Only cells addressable by the index field are ever reachable
    localparam int USED  = (CELLS < (1 << CELL_IDX_W)) ? CELLS : (1 << CELL_IDX_W);
    localparam int WORDS = (USED + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAP   = (CELLS < (1 << COUNT_W)) ? CELLS : ((1 << COUNT_W) - 1);

    typedef enum logic [0:0] {ST_IDLE, ST_RMW} state_t;

    state_t                state_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ACTION_W-1:0]   act_reg;
    logic [CELL_IDX_W-1:0] idx_reg;
    logic [AW-1:0]         word_reg;
    logic                  any_free_reg;
    logic                  oor_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CELL_IDX_W-1:0] out_index_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_busy_reg;

    logic [COUNT_W-1:0]    active_n;
    logic                  in_fire;
    logic [ACTION_W-1:0]   in_action;
    logic [CELL_IDX_W-1:0] in_index;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic                  free_found;
    logic [AW-1:0]         free_word;
    logic                  finish;
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;
    logic [BIT_W:0]        lz;
    logic [BIT_W-1:0]      bit_sel;
    logic [COUNT_W-1:0]    alloc_idx;
    logic [CELL_IDX_W-1:0] res_index;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_busy;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_action     = s_axis_tdata[ACTION_W-1:0];
    assign in_index      = s_axis_tdata[ACTION_W +: CELL_IDX_W];

    // Active cell count, saturated to the bitmap size
    assign active_n = (count_reg > COUNT_W'(CAP)) ? COUNT_W'(CAP) : count_reg;

    // Read address: summary hit for allocate, otherwise the indexed word
    assign rd_en   = in_fire;
    assign rd_addr = (in_action == ACT_ALLOC) ? free_word
                                              : AW'(in_index[CELL_IDX_W-1:BIT_W]);

    bca_map #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (word_reg),
        .wr_data    (wr_data),
        .free_found (free_found),
        .free_word  (free_word)
    );

    // Modify stage: decide the result and the write-back word
    assign finish    = (state_reg == ST_RMW) && (!out_valid_reg || m_axis_tready);
    assign lz        = low_zero(rd_data);
    assign alloc_idx = COUNT_W'({word_reg, lz[BIT_W-1:0]});
    assign bit_sel   = idx_reg[BIT_W-1:0];

    always_comb
    begin
        logic do_write;
        do_write   = 1'b0;
        wr_data    = rd_data;
        res_index  = idx_reg;
        res_status = STS_OK;
        res_busy   = 1'b0;
        priority if (act_reg == ACT_ALLOC)
        begin
            if (any_free_reg && lz[BIT_W] && (alloc_idx < active_n))
            begin
                do_write         = 1'b1;
                wr_data[lz[BIT_W-1:0]] = 1'b1;
                res_index        = alloc_idx[CELL_IDX_W-1:0];
            end
            else
            begin
                res_index  = '0;
                res_status = STS_FULL;
            end
        end
        else if (oor_reg)
        begin
            res_status = STS_RANGE;
        end
        else if (act_reg == ACT_FREE)
        begin
            if (rd_data[bit_sel])
            begin
                do_write         = 1'b1;
                wr_data[bit_sel] = 1'b0;
                res_busy         = 1'b1;
            end
            else
            begin
                res_status = STS_WAS_FREE;
            end
        end
        else
        begin
            res_busy = rd_data[bit_sel];
        end
        wr_en = finish && do_write;
    end

    // Result valid: a new result wins over the word leaving in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_RMW;
                    end
                end
                ST_RMW:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg      <= in_action;
            idx_reg      <= in_index;
            word_reg     <= rd_addr;
            any_free_reg <= free_found;
            oor_reg      <= ({1'b0, in_index} >= active_n);
        end
        if (finish)
        begin
            out_index_reg  <= res_index;
            out_status_reg <= res_status;
            out_busy_reg   <= res_busy;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {BUS_W'(0) | BUS_W'({out_busy_reg, out_status_reg, out_index_reg})};

endmodule

// ===== sv/bca_checker.sv =====
// Port-level checks for the bitmap cell allocator, bound to the top level.
// Depends on bca_pkg and bitmap_cell_allocator_unit.
module bca_checker
    import bca_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [BUS_W-1:0]   m_axis_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One request at a time: no request taken on the cycle after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken during read-modify-write");

    // Full report carries index zero and a clear busy flag
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] == STS_FULL)
            |-> (m_axis_tdata[7:0] == 8'd0) && !m_axis_tdata[10])
        else $error("full report with non-zero payload");

    // Failed free and range errors never report a busy cell
    a_no_busy_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[9:8] == STS_WAS_FREE)
                          || (m_axis_tdata[9:8] == STS_RANGE))
            |-> !m_axis_tdata[10])
        else $error("busy flag set on an error result");

endmodule

bind bitmap_cell_allocator_unit bca_checker u_bca_checker (.*);

// ===== test/bitmap_cell_allocator_unit_tb.sv =====
// Self-checking testbench for bitmap_cell_allocator_unit: predicts each result word
// from its own copy of the busy bitmap and cell count, with random idling on both sides.
// Depends on bca_pkg and the allocator RTL.
`timescale 1ns / 100ps

module bitmap_cell_allocator_unit_tb;
    import bca_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_IDLE = 12;

    // Spare action code, handled as a query
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic                  cell_busy;
        logic [STATUS_W-1:0]   status;
        logic [CELL_IDX_W-1:0] result_index;
    } cell_result_t;

    // Shadow bitmap, first-fit predictor and queue of outstanding result words
    class cell_map_scoreboard;
        bit              occupied [CELLS_DEFAULT];
        int unsigned     cell_count;
        cell_result_t    outstanding_q[$];
        int              errors;
        int              requests;
        int              checked;
        int              status_seen [4];

        function new();
            cell_count = 32'(COUNT_RESET);
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            cell_count = 32'(value);
        endfunction

        function int pending();
            return outstanding_q.size();
        endfunction

        function cell_result_t allocate_or_lookup(logic [ACTION_W-1:0] act,
                                                  logic [CELL_IDX_W-1:0] idx);
            cell_result_t r;
            int unsigned  limit;
            limit = (cell_count > CELLS_DEFAULT) ? CELLS_DEFAULT : cell_count;
            r = '0;
            // Allocate: lowest free cell below the active count
            if (act == ACT_ALLOC)
            begin
                for (int k = 0; k < limit; k++)
                begin
                    if (!occupied[k])
                    begin
                        occupied[k] = 1'b1;
                        r.result_index = k[CELL_IDX_W-1:0];
                        r.status = STS_OK;
                        return r;
                    end
                end
                r.status = STS_FULL;
                return r;
            end
            r.result_index = idx;
            if (idx >= limit)
            begin
                r.status = STS_RANGE;
                return r;
            end
            if (act == ACT_FREE)
            begin
                if (!occupied[idx])
                    r.status = STS_WAS_FREE;
                else
                begin
                    occupied[idx] = 1'b0;
                    r.status = STS_OK;
                    r.cell_busy = 1'b1;
                end
                return r;
            end
            // Query and the spare code
            r.status = STS_OK;
            r.cell_busy = occupied[idx];
            return r;
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [CELL_IDX_W-1:0] idx);
            outstanding_q.push_back(allocate_or_lookup(act, idx));
            requests++;
        endfunction

        function void check_result(logic [BUS_W-1:0] word);
            cell_result_t got;
            cell_result_t want;
            got = word[10:0];
            checked++;
            if (outstanding_q.size() == 0)
            begin
                $error("result word %h arrived with no request outstanding", word);
                errors++;
                return;
            end
            want = outstanding_q.pop_front();
            status_seen[got.status]++;
            if (got.result_index !== want.result_index)
            begin
                $error("result_index: expected %0d, got %0d", want.result_index,
                       got.result_index);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.cell_busy !== want.cell_busy)
            begin
                $error("cell_busy: expected %0d, got %0d", want.cell_busy, got.cell_busy);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BUS_W-1:0]   s_axis_tdata = '0;   // [1:0] action, [9:2] cell_index
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [BUS_W-1:0]   m_axis_tdata;        // [7:0] result_index, [9:8] status, [10] cell_busy

    cell_map_scoreboard cell_sb = new();
    int unsigned        cur_count = 32'(COUNT_RESET);
    int                 count_settings = 0;
    int                 cycles = 0;
    bit                 tx_fast = 1'b0;
    bit                 rx_fast = 1'b0;

    bitmap_cell_allocator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Request word; valid is only lowered when a gap is drawn
    task automatic send_request(logic [ACTION_W-1:0] act, logic [CELL_IDX_W-1:0] idx);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(BUS_W - ACTION_W - CELL_IDX_W){1'b0}}, idx, act};
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
        cell_sb.note_request(act, idx);
        if ($urandom_range(0, 29) == 0)
            tx_fast = !tx_fast;
    endtask

    // Drain outstanding requests, then write the cell count
    task automatic write_cell_count(logic [COUNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (cell_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        cfg_valid <= 1'b0;
        cell_sb.set_count(value);
        cur_count = 32'(value);
        count_settings++;
    endtask

    // Random traffic at one cell count; indices mostly inside the active range
    task automatic random_phase(logic [COUNT_W-1:0] count, int items, int alloc_pct,
                                int free_pct);
        int unsigned      limit;
        int               pick;
        logic [ACTION_W-1:0]   act;
        logic [CELL_IDX_W-1:0] idx;
        write_cell_count(count);
        limit = (cur_count > CELLS_DEFAULT) ? CELLS_DEFAULT : cur_count;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
                act = ACT_ALLOC;
            else if (pick < alloc_pct + free_pct)
                act = ACT_FREE;
            else if ($urandom_range(0, 4) == 0)
                act = ACT_SPARE;
            else
                act = ACT_QUERY;
            if (limit > 0 && $urandom_range(0, 9) < 8)
                idx = CELL_IDX_W'($urandom_range(0, limit - 1));
            else
                idx = CELL_IDX_W'($urandom_range(0, 255));
            send_request(act, idx);
        end
    endtask

    // Result side: random back-pressure with stretches of none
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
            cell_sb.check_result(m_axis_tdata);
            if ($urandom_range(0, 29) == 0)
                rx_fast = !rx_fast;
        end
    end

    // Stimulus
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Three cells: fill, full, free twice, range edge, spare code
        write_cell_count(9'd3);
        send_request(ACT_ALLOC, 8'hFF);
        send_request(ACT_ALLOC, 8'h00);
        send_request(ACT_ALLOC, 8'h7F);
        send_request(ACT_ALLOC, 8'h01);
        send_request(ACT_FREE, 8'd1);
        send_request(ACT_FREE, 8'd1);
        send_request(ACT_QUERY, 8'd0);
        send_request(ACT_QUERY, 8'd1);
        send_request(ACT_QUERY, 8'd3);
        send_request(ACT_FREE, 8'd255);
        send_request(ACT_SPARE, 8'd2);
        send_request(ACT_ALLOC, 8'h80);

        // Zero cells: nothing reachable
        write_cell_count(9'd0);
        send_request(ACT_ALLOC, 8'h00);
        send_request(ACT_FREE, 8'd0);
        send_request(ACT_QUERY, 8'd0);

        // Count above the bitmap size saturates
        write_cell_count(9'd511);
        send_request(ACT_QUERY, 8'd255);
        send_request(ACT_QUERY, 8'd2);
        send_request(ACT_FREE, 8'd0);
        send_request(ACT_ALLOC, 8'hAA);
        send_request(ACT_FREE, 8'h55);
        send_request(ACT_QUERY, 8'hAA);

        // Fill the whole map, then shrink and grow over the leftover bits
        random_phase(9'd256, 380, 80, 10);
        random_phase(9'd8, 110, 40, 40);
        random_phase(9'd1, 40, 45, 35);
        random_phase(9'd0, 15, 34, 33);
        random_phase(9'd300, 80, 40, 40);
        random_phase(9'd100, 150, 35, 45);
        random_phase(9'd256, 150, 20, 60);

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (cell_sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests over %0d cell count settings; %0d result words checked.",
                 cell_sb.requests, count_settings, cell_sb.checked);
        $display("Outcomes: %0d ok, %0d full, %0d already free, %0d out of range.",
                 cell_sb.status_seen[STS_OK], cell_sb.status_seen[STS_FULL],
                 cell_sb.status_seen[STS_WAS_FREE], cell_sb.status_seen[STS_RANGE]);
        if (cell_sb.errors == 0 && cell_sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
